// ===== src/dlls_pkg.sv =====
// ----------------------------------------------------------------------------
// dlls_pkg
// shared codes, state type and control groups of the linked list store
// ----------------------------------------------------------------------------
package dlls_pkg;

    localparam int ACTION_WIDTH = 2;
    localparam int VALUE_WIDTH  = 32;
    localparam int STATUS_WIDTH = 2;
    localparam int COUNT_WIDTH  = 5;

    localparam logic [ACTION_WIDTH-1:0] ACT_INS_FRONT = 2'd0;
    localparam logic [ACTION_WIDTH-1:0] ACT_INS_BACK  = 2'd1;
    localparam logic [ACTION_WIDTH-1:0] ACT_DELETE    = 2'd2;
    localparam logic [ACTION_WIDTH-1:0] ACT_SEARCH    = 2'd3;

    localparam logic [STATUS_WIDTH-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] STAT_EMPTY     = 2'd2;
    localparam logic [STATUS_WIDTH-1:0] STAT_FULL      = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_INS_NODE,
        ST_INS_LINK,
        ST_WALK,
        ST_DEL_PREV,
        ST_DEL_NEXT,
        ST_DONE
    } state_t;

    // field write enables of the node memory
    typedef struct packed {
        logic value;
        logic next;
        logic prev;
    } node_we_t;

    // commands to the free map
    typedef struct packed {
        logic scan;
        logic take;
        logic give;
    } free_cmd_t;

endpackage

// ===== src/dlls_if.sv =====
// ----------------------------------------------------------------------------
// dlls_if
// request and response channels of the linked list store
// ----------------------------------------------------------------------------
interface dlls_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [dlls_pkg::ACTION_WIDTH-1:0]     action;
    logic signed [dlls_pkg::VALUE_WIDTH-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface dlls_out_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  found;
    logic [dlls_pkg::STATUS_WIDTH-1:0]     status;
    logic [dlls_pkg::COUNT_WIDTH-1:0]      count;

    modport source (output valid, output found, output status, output count, input ready);
    modport sink   (input valid, input found, input status, input count, output ready);
endinterface

// ===== src/doubly_linked_list_store.sv =====
// ----------------------------------------------------------------------------
// doubly_linked_list_store
// bounded doubly linked list of signed values in a node pool
// ----------------------------------------------------------------------------
// One request word is taken at a time and gives one response word. The node
// memory has a single registered read port, so a walk visits one node per
// cycle. An insert with room first scans the free map serially from entry
// zero up to the lowest free entry; a search walks from the head up to the
// match, a delete then passes two relinking states, and a miss walks the
// whole list. The response sits in an output register, so the next request
// is accepted while it waits. No clearing pass is needed after reset.
module doubly_linked_list_store #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    dlls_in_if.sink     req,
    dlls_out_if.source  rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int IW = $clog2(CAPACITY + 1);

    logic [AW-1:0]         mem_rd_addr;
    logic [DATA_WIDTH-1:0] mem_rd_value;
    logic [IW-1:0]         mem_rd_next;
    logic [IW-1:0]         mem_rd_prev;
    logic [AW-1:0]         mem_wr_addr;
    dlls_pkg::node_we_t    mem_wr_en;
    logic [DATA_WIDTH-1:0] mem_wr_value;
    logic [IW-1:0]         mem_wr_next;
    logic [IW-1:0]         mem_wr_prev;
    dlls_pkg::free_cmd_t   fm_cmd;
    logic [AW-1:0]         fm_idx;
    logic                  fm_hit;
    logic [AW-1:0]         fm_hit_idx;

    dlls_node_mem #(
        .DEPTH      (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH),
        .LINK_WIDTH (IW)
    ) u_node_mem (
        .clk      (clk),
        .rd_addr  (mem_rd_addr),
        .rd_value (mem_rd_value),
        .rd_next  (mem_rd_next),
        .rd_prev  (mem_rd_prev),
        .wr_addr  (mem_wr_addr),
        .wr_en    (mem_wr_en),
        .wr_value (mem_wr_value),
        .wr_next  (mem_wr_next),
        .wr_prev  (mem_wr_prev)
    );

    dlls_free_map #(
        .CAPACITY (CAPACITY)
    ) u_free_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (fm_cmd),
        .idx     (fm_idx),
        .hit     (fm_hit),
        .hit_idx (fm_hit_idx)
    );

    dlls_ctrl #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .rsp          (rsp),
        .mem_rd_addr  (mem_rd_addr),
        .mem_rd_value (mem_rd_value),
        .mem_rd_next  (mem_rd_next),
        .mem_rd_prev  (mem_rd_prev),
        .mem_wr_addr  (mem_wr_addr),
        .mem_wr_en    (mem_wr_en),
        .mem_wr_value (mem_wr_value),
        .mem_wr_next  (mem_wr_next),
        .mem_wr_prev  (mem_wr_prev),
        .fm_cmd       (fm_cmd),
        .fm_idx       (fm_idx),
        .fm_hit       (fm_hit),
        .fm_hit_idx   (fm_hit_idx)
    );

endmodule

// ===== src/dlls_node_mem.sv =====
// ----------------------------------------------------------------------------
// dlls_node_mem
// node pool memory: value, forward and backward link per entry
// ----------------------------------------------------------------------------
module dlls_node_mem #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int LINK_WIDTH = 5
) (
    input  logic                         clk,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr,
    output logic [DATA_WIDTH-1:0]        rd_value,
    output logic [LINK_WIDTH-1:0]        rd_next,
    output logic [LINK_WIDTH-1:0]        rd_prev,
    input  logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  dlls_pkg::node_we_t           wr_en,
    input  logic [DATA_WIDTH-1:0]        wr_value,
    input  logic [LINK_WIDTH-1:0]        wr_next,
    input  logic [LINK_WIDTH-1:0]        wr_prev
);

    localparam int WORD_WIDTH = DATA_WIDTH + 2 * LINK_WIDTH;

    logic [WORD_WIDTH-1:0] mem [DEPTH];
    logic [WORD_WIDTH-1:0] rd_word_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en.value)
        begin
            mem[wr_addr][DATA_WIDTH-1:0] <= wr_value;
        end
        if (wr_en.next)
        begin
            mem[wr_addr][DATA_WIDTH +: LINK_WIDTH] <= wr_next;
        end
        if (wr_en.prev)
        begin
            mem[wr_addr][DATA_WIDTH + LINK_WIDTH +: LINK_WIDTH] <= wr_prev;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_word_reg <= mem[rd_addr];
    end

    assign rd_value = rd_word_reg[DATA_WIDTH-1:0];
    assign rd_next  = rd_word_reg[DATA_WIDTH +: LINK_WIDTH];
    assign rd_prev  = rd_word_reg[DATA_WIDTH + LINK_WIDTH +: LINK_WIDTH];

endmodule

// ===== src/dlls_free_map.sv =====
// ----------------------------------------------------------------------------
// dlls_free_map
// free bit per pool entry with a serial lowest-index allocator
// ----------------------------------------------------------------------------
module dlls_free_map #(
    parameter int CAPACITY = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dlls_pkg::free_cmd_t           cmd,
    input  logic [$clog2(CAPACITY)-1:0]   idx,
    output logic                          hit,
    output logic [$clog2(CAPACITY)-1:0]   hit_idx
);

    localparam int AW = $clog2(CAPACITY);

    logic [CAPACITY-1:0] free_reg;
    logic [CAPACITY-1:0] free_next;
    logic [AW-1:0]       scan_reg;
    logic [AW-1:0]       scan_next;

    assign hit     = free_reg[scan_reg];
    assign hit_idx = scan_reg;

    always_comb
    begin
        free_next = free_reg;
        if (cmd.take)
        begin
            free_next[idx] = 1'b0;
        end
        if (cmd.give)
        begin
            free_next[idx] = 1'b1;
        end
    end

    always_comb
    begin
        if (!cmd.scan)
        begin
            scan_next = '0;
        end
        else if (hit)
        begin
            scan_next = scan_reg;
        end
        else
        begin
            scan_next = scan_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg <= '1;
            scan_reg <= '0;
        end
        else
        begin
            free_reg <= free_next;
            scan_reg <= scan_next;
        end
    end

    a_take_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |-> free_reg[idx])
        else $error("allocated entry was not free");

    a_release_used: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.give |-> !free_reg[idx])
        else $error("released entry was already free");

endmodule

// ===== src/dlls_ctrl.sv =====
// ----------------------------------------------------------------------------
// dlls_ctrl
// request sequencer: allocation, list walk, relinking and response register
// ----------------------------------------------------------------------------
module dlls_ctrl #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    dlls_in_if.sink                               req,
    dlls_out_if.source                            rsp,
    output logic [$clog2(CAPACITY)-1:0]           mem_rd_addr,
    input  logic [DATA_WIDTH-1:0]                 mem_rd_value,
    input  logic [$clog2(CAPACITY+1)-1:0]         mem_rd_next,
    input  logic [$clog2(CAPACITY+1)-1:0]         mem_rd_prev,
    output logic [$clog2(CAPACITY)-1:0]           mem_wr_addr,
    output dlls_pkg::node_we_t                    mem_wr_en,
    output logic [DATA_WIDTH-1:0]                 mem_wr_value,
    output logic [$clog2(CAPACITY+1)-1:0]         mem_wr_next,
    output logic [$clog2(CAPACITY+1)-1:0]         mem_wr_prev,
    output dlls_pkg::free_cmd_t                   fm_cmd,
    output logic [$clog2(CAPACITY)-1:0]           fm_idx,
    input  logic                                  fm_hit,
    input  logic [$clog2(CAPACITY)-1:0]           fm_hit_idx
);

    localparam int AW = $clog2(CAPACITY);
    localparam int IW = $clog2(CAPACITY + 1);
    localparam int VW = dlls_pkg::VALUE_WIDTH;
    localparam int CO = dlls_pkg::COUNT_WIDTH;
    localparam logic [IW-1:0] NULL_IDX = IW'(CAPACITY);

    dlls_pkg::state_t state_reg;
    dlls_pkg::state_t state_next;

    logic [IW-1:0]                     head_reg, head_next;
    logic [IW-1:0]                     tail_reg, tail_next;
    logic [IW-1:0]                     count_reg, count_next;
    logic [dlls_pkg::ACTION_WIDTH-1:0] action_reg, action_next;
    logic [DATA_WIDTH-1:0]             key_reg, key_next;
    logic [IW-1:0]                     cur_reg, cur_next;
    logic [IW-1:0]                     steps_reg, steps_next;
    logic [IW-1:0]                     tgt_reg, tgt_next;
    logic [IW-1:0]                     prev_reg, prev_next;
    logic [IW-1:0]                     nxt_reg, nxt_next;
    logic [IW-1:0]                     link_reg, link_next;
    logic [AW-1:0]                     new_reg, new_next;
    logic                              found_reg, found_next;
    logic [dlls_pkg::STATUS_WIDTH-1:0] status_reg, status_next;
    logic                              out_valid_reg, out_valid_next;
    logic                              out_found_reg, out_found_next;
    logic [dlls_pkg::STATUS_WIDTH-1:0] out_status_reg, out_status_next;
    logic [CO-1:0]                     out_count_reg, out_count_next;

    logic [DATA_WIDTH+VW-1:0] key_ext;
    logic [IW+CO-1:0]         count_ext;
    logic                     head_null;
    logic                     tail_null;
    logic                     full;
    logic                     req_insert;
    logic                     act_insert;
    logic                     act_front;
    logic                     walk_end;
    logic                     walk_hit;
    logic                     out_free;

    assign key_ext    = {{DATA_WIDTH{1'b0}}, req.value};
    assign count_ext  = {{CO{1'b0}}, count_reg};
    assign head_null  = head_reg >= NULL_IDX;
    assign tail_null  = tail_reg >= NULL_IDX;
    assign full       = count_reg >= NULL_IDX;
    assign req_insert = (req.action == dlls_pkg::ACT_INS_FRONT)
                     || (req.action == dlls_pkg::ACT_INS_BACK);
    assign act_insert = (action_reg == dlls_pkg::ACT_INS_FRONT)
                     || (action_reg == dlls_pkg::ACT_INS_BACK);
    assign act_front  = action_reg == dlls_pkg::ACT_INS_FRONT;
    assign walk_end   = (cur_reg >= NULL_IDX) || (steps_reg >= NULL_IDX);
    assign walk_hit   = mem_rd_value == key_reg;
    assign out_free   = !out_valid_reg || rsp.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dlls_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req_insert)
                    begin
                        state_next = full ? dlls_pkg::ST_DONE : dlls_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = head_null ? dlls_pkg::ST_DONE : dlls_pkg::ST_WALK;
                    end
                end
            end
            dlls_pkg::ST_SCAN:
            begin
                if (fm_hit)
                begin
                    state_next = dlls_pkg::ST_INS_NODE;
                end
            end
            dlls_pkg::ST_INS_NODE:
            begin
                if (head_null || (!act_front && tail_null))
                begin
                    state_next = dlls_pkg::ST_DONE;
                end
                else
                begin
                    state_next = dlls_pkg::ST_INS_LINK;
                end
            end
            dlls_pkg::ST_INS_LINK:
            begin
                state_next = dlls_pkg::ST_DONE;
            end
            dlls_pkg::ST_WALK:
            begin
                if (walk_end)
                begin
                    state_next = dlls_pkg::ST_DONE;
                end
                else if (walk_hit)
                begin
                    state_next = (action_reg == dlls_pkg::ACT_DELETE)
                               ? dlls_pkg::ST_DEL_PREV : dlls_pkg::ST_DONE;
                end
            end
            dlls_pkg::ST_DEL_PREV:
            begin
                state_next = dlls_pkg::ST_DEL_NEXT;
            end
            dlls_pkg::ST_DEL_NEXT:
            begin
                state_next = dlls_pkg::ST_DONE;
            end
            dlls_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = dlls_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dlls_pkg::ST_IDLE;
            end
        endcase
    end

    // memory, free map and handshake controls
    always_comb
    begin
        req.ready    = 1'b0;
        mem_rd_addr  = cur_reg[AW-1:0];
        mem_wr_addr  = new_reg;
        mem_wr_en    = '0;
        mem_wr_value = key_reg;
        mem_wr_next  = NULL_IDX;
        mem_wr_prev  = NULL_IDX;
        fm_cmd       = '0;
        fm_idx       = new_reg;
        unique case (state_reg)
            dlls_pkg::ST_IDLE:
            begin
                req.ready   = 1'b1;
                mem_rd_addr = head_reg[AW-1:0];
            end
            dlls_pkg::ST_SCAN:
            begin
                fm_cmd.scan = 1'b1;
            end
            dlls_pkg::ST_INS_NODE:
            begin
                mem_wr_en   = '1;
                fm_cmd.take = 1'b1;
                if (!head_null)
                begin
                    if (act_front)
                    begin
                        mem_wr_next = head_reg;
                    end
                    else
                    begin
                        mem_wr_prev = tail_reg;
                    end
                end
            end
            dlls_pkg::ST_INS_LINK:
            begin
                mem_wr_addr = link_reg[AW-1:0];
                mem_wr_next = IW'(new_reg);
                mem_wr_prev = IW'(new_reg);
                if (act_front)
                begin
                    mem_wr_en.prev = 1'b1;
                end
                else
                begin
                    mem_wr_en.next = 1'b1;
                end
            end
            dlls_pkg::ST_WALK:
            begin
                mem_rd_addr = mem_rd_next[AW-1:0];
            end
            dlls_pkg::ST_DEL_PREV:
            begin
                mem_wr_addr    = prev_reg[AW-1:0];
                mem_wr_next    = nxt_reg;
                mem_wr_en.next = prev_reg < NULL_IDX;
            end
            dlls_pkg::ST_DEL_NEXT:
            begin
                mem_wr_addr    = nxt_reg[AW-1:0];
                mem_wr_prev    = prev_reg;
                mem_wr_en.prev = nxt_reg < NULL_IDX;
                fm_cmd.give    = 1'b1;
                fm_idx         = tgt_reg[AW-1:0];
            end
            dlls_pkg::ST_DONE:
            begin
                req.ready = 1'b0;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        action_next     = action_reg;
        key_next        = key_reg;
        cur_next        = cur_reg;
        steps_next      = steps_reg;
        tgt_next        = tgt_reg;
        prev_next       = prev_reg;
        nxt_next        = nxt_reg;
        link_next       = link_reg;
        new_next        = new_reg;
        found_next      = found_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_found_next  = out_found_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        case (state_reg)
            dlls_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    action_next = req.action;
                    key_next    = key_ext[DATA_WIDTH-1:0];
                    cur_next    = head_reg;
                    steps_next  = '0;
                    found_next  = 1'b0;
                    status_next = dlls_pkg::STAT_OK;
                    if (req_insert && full)
                    begin
                        status_next = dlls_pkg::STAT_FULL;
                    end
                    else if (!req_insert && head_null)
                    begin
                        status_next = dlls_pkg::STAT_EMPTY;
                    end
                end
            end
            dlls_pkg::ST_SCAN:
            begin
                new_next = fm_hit_idx;
            end
            dlls_pkg::ST_INS_NODE:
            begin
                count_next = count_reg + IW'(1);
                if (head_null)
                begin
                    head_next = IW'(new_reg);
                    tail_next = IW'(new_reg);
                end
                else if (act_front)
                begin
                    link_next = head_reg;
                    head_next = IW'(new_reg);
                end
                else
                begin
                    link_next = tail_reg;
                    tail_next = IW'(new_reg);
                end
            end
            dlls_pkg::ST_WALK:
            begin
                if (walk_end)
                begin
                    status_next = dlls_pkg::STAT_NOT_FOUND;
                end
                else if (walk_hit)
                begin
                    found_next = 1'b1;
                    tgt_next   = cur_reg;
                    prev_next  = mem_rd_prev;
                    nxt_next   = mem_rd_next;
                end
                else
                begin
                    cur_next   = mem_rd_next;
                    steps_next = steps_reg + IW'(1);
                end
            end
            dlls_pkg::ST_DEL_PREV:
            begin
                if (prev_reg >= NULL_IDX)
                begin
                    head_next = nxt_reg;
                end
            end
            dlls_pkg::ST_DEL_NEXT:
            begin
                if (nxt_reg >= NULL_IDX)
                begin
                    tail_next = prev_reg;
                end
                if (count_reg != '0)
                begin
                    count_next = count_reg - IW'(1);
                end
            end
            dlls_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_found_next  = found_reg;
                    out_status_next = status_reg;
                    out_count_next  = count_ext[CO-1:0];
                end
            end
            default:
            begin
                found_next = found_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dlls_pkg::ST_IDLE;
            head_reg      <= NULL_IDX;
            tail_reg      <= NULL_IDX;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        key_reg        <= key_next;
        cur_reg        <= cur_next;
        steps_reg      <= steps_next;
        tgt_reg        <= tgt_next;
        prev_reg       <= prev_next;
        nxt_reg        <= nxt_next;
        link_reg       <= link_next;
        new_reg        <= new_next;
        found_reg      <= found_next;
        status_reg     <= status_next;
        out_found_reg  <= out_found_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.found  = out_found_reg;
    assign rsp.status = out_status_reg;
    assign rsp.count  = out_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NULL_IDX)
        else $error("entry count above capacity");

    a_head_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dlls_pkg::ST_IDLE) |-> (head_null == (count_reg == '0)))
        else $error("head pointer disagrees with entry count");

    a_head_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dlls_pkg::ST_IDLE) |-> (head_null == tail_null))
        else $error("head and tail pointers disagree on empty list");

endmodule

// ===== sim/doubly_linked_list_store_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// doubly_linked_list_store_tb
// self-checking bench for the linked list store: a short directed table over
// empty, extreme, duplicate and full cases, then biased random grow and
// shrink traffic under several idle and stall mixes, every response word
// compared with its table row or a queue-based shadow of the list contents
// ----------------------------------------------------------------------------
module doubly_linked_list_store_tb;

    localparam int CAPACITY      = 16;
    localparam int RANDOM_ITEMS  = 1600;
    localparam int PHASE_ITEMS   = RANDOM_ITEMS / 4;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 5000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int PLAN_ROWS     = 28;

    typedef struct packed {
        logic                              found;
        logic [dlls_pkg::STATUS_WIDTH-1:0] status;
        logic [dlls_pkg::COUNT_WIDTH-1:0]  count;
    } rsp_word_t;

    typedef struct packed {
        logic [dlls_pkg::ACTION_WIDTH-1:0] act;
        logic [dlls_pkg::VALUE_WIDTH-1:0]  val;
        logic                              typed;
        rsp_word_t                         rsp;
    } plan_row_t;

    logic clk;
    logic rst_n;

    dlls_in_if  req_if ();
    dlls_out_if rsp_if ();

    doubly_linked_list_store #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (dlls_pkg::VALUE_WIDTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    logic [dlls_pkg::VALUE_WIDTH-1:0] list_values[$];
    rsp_word_t                        pending_rsp[$];
    plan_row_t                        directed_plan[PLAN_ROWS];
    logic [dlls_pkg::VALUE_WIDTH-1:0] palette[16];

    int   errors;
    int   send_idle_pct;
    int   rsp_stall_pct;
    logic hold_req;
    logic hold_seen;
    int   hold_left;
    int   quiet_cycles;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // shadow of the list: front of the queue is the head
    function automatic rsp_word_t apply_request(
        input logic [dlls_pkg::ACTION_WIDTH-1:0] act,
        input logic [dlls_pkg::VALUE_WIDTH-1:0]  val);
        rsp_word_t r;
        int        hit;
        r   = '0;
        hit = -1;
        if (act == dlls_pkg::ACT_INS_FRONT || act == dlls_pkg::ACT_INS_BACK)
        begin
            if (list_values.size() >= CAPACITY)
                r.status = dlls_pkg::STAT_FULL;
            else
            begin
                if (act == dlls_pkg::ACT_INS_FRONT)
                    list_values.push_front(val);
                else
                    list_values.push_back(val);
                r.status = dlls_pkg::STAT_OK;
            end
        end
        else if (list_values.size() == 0)
            r.status = dlls_pkg::STAT_EMPTY;
        else
        begin
            for (int i = 0; i < list_values.size(); i++)
            begin
                if (hit < 0 && list_values[i] == val)
                    hit = i;
            end
            if (hit < 0)
                r.status = dlls_pkg::STAT_NOT_FOUND;
            else
            begin
                r.found  = 1'b1;
                r.status = dlls_pkg::STAT_OK;
                if (act == dlls_pkg::ACT_DELETE)
                    list_values.delete(hit);
            end
        end
        r.count = dlls_pkg::COUNT_WIDTH'(list_values.size());
        return r;
    endfunction

    function automatic plan_row_t row(input logic [dlls_pkg::ACTION_WIDTH-1:0] act,
                                      input logic [dlls_pkg::VALUE_WIDTH-1:0] val,
                                      input logic typed,
                                      input logic found,
                                      input logic [dlls_pkg::STATUS_WIDTH-1:0] status,
                                      input logic [dlls_pkg::COUNT_WIDTH-1:0] count);
        plan_row_t p;
        p.act        = act;
        p.val        = val;
        p.typed      = typed;
        p.rsp.found  = found;
        p.rsp.status = status;
        p.rsp.count  = count;
        return p;
    endfunction

    task automatic send_word(input logic [dlls_pkg::ACTION_WIDTH-1:0] act,
                             input logic [dlls_pkg::VALUE_WIDTH-1:0] val,
                             input logic typed,
                             input rsp_word_t typed_rsp);
        rsp_word_t predicted;
        int        gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid  <= 1'b1;
        req_if.action <= act;
        req_if.value  <= val;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        predicted = apply_request(act, val);
        pending_rsp.push_back(typed ? typed_rsp : predicted);
    endtask

    // response side: checks accepted words, drives ready
    always @(posedge clk or negedge rst_n)
    begin : rsp_side
        rsp_word_t want;
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            hold_seen    <= 1'b0;
            hold_left    = 0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (pending_rsp.size() == 0)
                begin
                    $display("%0t: unexpected word found %0d status %0d count %0d",
                             $time, rsp_if.found, rsp_if.status, rsp_if.count);
                    errors++;
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    if (rsp_if.found !== want.found)
                    begin
                        $display("%0t: found expected %0d actual %0d",
                                 $time, want.found, rsp_if.found);
                        errors++;
                    end
                    if (rsp_if.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, rsp_if.status);
                        errors++;
                    end
                    if (rsp_if.count !== want.count)
                    begin
                        $display("%0t: count expected %0d actual %0d",
                                 $time, want.count, rsp_if.count);
                        errors++;
                    end
                end
            end
            if (hold_req && !hold_seen)
                hold_left = HOLD_CYCLES;
            hold_seen <= hold_req;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else
        begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("doubly_linked_list_store: mismatch");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        logic [dlls_pkg::ACTION_WIDTH-1:0] act;
        logic [dlls_pkg::VALUE_WIDTH-1:0]  val;
        int                                pick;
        logic                              grow;

        rst_n         = 1'b0;
        req_if.valid  = 1'b0;
        req_if.action = dlls_pkg::ACT_INS_FRONT;
        req_if.value  = '0;
        errors        = 0;
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        hold_req      = 1'b0;

        directed_plan = '{
            row(dlls_pkg::ACT_SEARCH,    32'h0000_0000, 1'b1, 1'b0,
                dlls_pkg::STAT_EMPTY,     5'd0),
            row(dlls_pkg::ACT_DELETE,    32'h7fff_ffff, 1'b1, 1'b0,
                dlls_pkg::STAT_EMPTY,     5'd0),
            row(dlls_pkg::ACT_INS_FRONT, 32'h7fff_ffff, 1'b1, 1'b0,
                dlls_pkg::STAT_OK,        5'd1),
            row(dlls_pkg::ACT_INS_BACK,  32'h8000_0000, 1'b1, 1'b0,
                dlls_pkg::STAT_OK,        5'd2),
            row(dlls_pkg::ACT_SEARCH,    32'h8000_0000, 1'b1, 1'b1,
                dlls_pkg::STAT_OK,        5'd2),
            row(dlls_pkg::ACT_SEARCH,    32'h0000_0000, 1'b1, 1'b0,
                dlls_pkg::STAT_NOT_FOUND, 5'd2),
            row(dlls_pkg::ACT_DELETE,    32'h8000_0000, 1'b1, 1'b1,
                dlls_pkg::STAT_OK,        5'd1),
            row(dlls_pkg::ACT_DELETE,    32'h0000_0000, 1'b1, 1'b0,
                dlls_pkg::STAT_NOT_FOUND, 5'd1),
            row(dlls_pkg::ACT_INS_FRONT, 32'hffff_ffff, 1'b0, 1'b0, dlls_pkg::STAT_OK, 5'd0),
            row(dlls_pkg::ACT_INS_BACK,  32'h0000_0000, 1'b0, 1'b0, dlls_pkg::STAT_OK, 5'd0),
            row(dlls_pkg::ACT_INS_FRONT, 32'h0000_0005, 1'b0, 1'b0, dlls_pkg::STAT_OK, 5'd0),
            row(dlls_pkg::ACT_INS_BACK,  32'h0000_0005, 1'b0, 1'b0, dlls_pkg::STAT_OK, 5'd0),
            row(dlls_pkg::ACT_INS_BACK,  32'h8000_0000, 1'b0, 1'b0, dlls_pkg::STAT_OK, 5'd0),
            row(dlls_pkg::ACT_INS_FRONT, 32'h5555_5555, 1'b0, 1'b0, dlls_pkg::STAT_OK, 5'd0),
            row(dlls_pkg::ACT_INS_BACK,  32'haaaa_aaaa, 1'b0, 1'b0, dlls_pkg::STAT_OK, 5'd0),
            row(dlls_pkg::ACT_INS_FRONT, 32'h0000_0001, 1'b0, 1'b0, dlls_pkg::STAT_OK, 5'd0),
            row(dlls_pkg::ACT_INS_BACK,  32'h0000_0002, 1'b0, 1'b0, dlls_pkg::STAT_OK, 5'd0),
            row(dlls_pkg::ACT_INS_FRONT, 32'h0000_0005, 1'b0, 1'b0, dlls_pkg::STAT_OK, 5'd0),
            row(dlls_pkg::ACT_INS_BACK,  32'h1234_5678, 1'b0, 1'b0, dlls_pkg::STAT_OK, 5'd0),
            row(dlls_pkg::ACT_INS_FRONT, 32'hdead_beef, 1'b0, 1'b0, dlls_pkg::STAT_OK, 5'd0),
            row(dlls_pkg::ACT_INS_BACK,  32'h0000_0003, 1'b0, 1'b0, dlls_pkg::STAT_OK, 5'd0),
            row(dlls_pkg::ACT_INS_FRONT, 32'h0000_0004, 1'b0, 1'b0, dlls_pkg::STAT_OK, 5'd0),
            row(dlls_pkg::ACT_INS_BACK,  32'h0000_0006, 1'b0, 1'b0, dlls_pkg::STAT_OK, 5'd0),
            row(dlls_pkg::ACT_INS_BACK,  32'h0000_0007, 1'b0, 1'b0, dlls_pkg::STAT_OK, 5'd0),
            row(dlls_pkg::ACT_INS_FRONT, 32'h0000_0008, 1'b1, 1'b0,
                dlls_pkg::STAT_FULL,      5'd16),
            row(dlls_pkg::ACT_INS_BACK,  32'h0000_0009, 1'b1, 1'b0,
                dlls_pkg::STAT_FULL,      5'd16),
            row(dlls_pkg::ACT_DELETE,    32'h0000_0005, 1'b0, 1'b0, dlls_pkg::STAT_OK, 5'd0),
            row(dlls_pkg::ACT_DELETE,    32'h0000_0000, 1'b0, 1'b0, dlls_pkg::STAT_OK, 5'd0)
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[i])
            send_word(directed_plan[i].act, directed_plan[i].val,
                      directed_plan[i].typed, directed_plan[i].rsp);

        // receiver holds off while words keep coming, so the input backs up
        hold_req <= 1'b1;

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct <= 0;  rsp_stall_pct <= 0;  end
                1: begin send_idle_pct <= 59; rsp_stall_pct <= 0;  end
                2: begin send_idle_pct <= 0;  rsp_stall_pct <= 59; end
                default: begin send_idle_pct <= 18; rsp_stall_pct <= 18; end
            endcase
            palette[0] = 32'h8000_0000;
            palette[1] = 32'h7fff_ffff;
            palette[2] = 32'h0000_0000;
            palette[3] = 32'hffff_ffff;
            for (int k = 4; k < 16; k++)
                palette[k] = $urandom;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                grow = ((n / 40) % 2) == 0;
                pick = $urandom_range(0, 99);
                if (grow)
                    act = (pick < 35) ? dlls_pkg::ACT_INS_FRONT :
                          (pick < 65) ? dlls_pkg::ACT_INS_BACK :
                          (pick < 80) ? dlls_pkg::ACT_DELETE : dlls_pkg::ACT_SEARCH;
                else
                    act = (pick < 10) ? dlls_pkg::ACT_INS_FRONT :
                          (pick < 20) ? dlls_pkg::ACT_INS_BACK :
                          (pick < 70) ? dlls_pkg::ACT_DELETE : dlls_pkg::ACT_SEARCH;
                if ($urandom_range(0, 99) < 85)
                    val = palette[$urandom_range(0, 15)];
                else
                    val = $urandom;
                send_word(act, val, 1'b0, '0);
            end
        end
        req_if.valid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("doubly_linked_list_store: match");
        else
            $display("doubly_linked_list_store: mismatch");
        $finish;
    end

endmodule
